[hdl/min_pulse_output_controller_assert.svh]
// ----------------------------------------------------------------------------
// min_pulse_output_controller_assert.svh
// assertion macros shared by the output controller modules
// ----------------------------------------------------------------------------
`ifndef MIN_PULSE_OUTPUT_CONTROLLER_ASSERT_SVH
`define MIN_PULSE_OUTPUT_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define MPOC_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("mpoc assertion failed");

// next-cycle implication, checked out of reset
`define MPOC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("mpoc assertion failed");

`else

`define MPOC_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs)
`define MPOC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

[hdl/mpoc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpoc_pkg
// types and constants of the minimum pulse output controller
// ----------------------------------------------------------------------------
package mpoc_pkg;

  localparam int NUM_OUTPUTS = 4;
  localparam int HOLD_WIDTH  = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [HOLD_WIDTH-1:0] HOLD_ONE = HOLD_WIDTH'(1);
  localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = '1;

  // opcodes
  localparam logic [2:0] OP_SET    = 3'd0;
  localparam logic [2:0] OP_TICK   = 3'd1;
  localparam logic [2:0] OP_FORCE  = 3'd2;
  localparam logic [2:0] OP_ENABLE = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE3 = 3'd5;

  typedef struct packed {
    logic [2:0] opcode;
    logic [1:0] channel;
    logic       level_req;
    logic       force_on;
  } in_item_t;

  typedef struct packed {
    logic [NUM_OUTPUTS-1:0] pin_levels;
    logic [NUM_OUTPUTS-1:0] logical_mask;
    logic [NUM_OUTPUTS-1:0] forced_mask;
    logic                   outputs_on;
  } out_item_t;

  // request broadcast to every channel
  typedef struct packed {
    logic       fire;
    logic [2:0] opcode;
    logic       sel;
    logic       level_req;
    logic       force_on;
    logic       enabled;
  } chan_cmd_t;

  // channel status after the request
  typedef struct packed {
    logic logical;
    logic forced;
  } chan_stat_t;

endpackage
`default_nettype wire

[hdl/mpoc_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpoc_cfg_regs
// configuration registers: pin inversion, active level, minimum pulse widths
// ----------------------------------------------------------------------------
module mpoc_cfg_regs (
  input  wire logic                                                  clk,
  input  wire logic                                                  rst_n,
  input  wire logic                                                  cfg_we,
  input  wire logic [mpoc_pkg::CFG_IDX_W-1:0]                        cfg_index,
  input  wire logic [mpoc_pkg::CFG_DATA_W-1:0]                       cfg_data,
  output logic [mpoc_pkg::NUM_OUTPUTS-1:0]                           invert_mask,
  output logic                                                       active_level,
  output logic [mpoc_pkg::NUM_OUTPUTS-1:0][mpoc_pkg::HOLD_WIDTH-1:0] min_pulse
);

  logic [mpoc_pkg::NUM_OUTPUTS-1:0]                           invert_r;
  logic                                                       active_r;
  logic [mpoc_pkg::NUM_OUTPUTS-1:0][mpoc_pkg::HOLD_WIDTH-1:0] pulse_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= '0;
      active_r <= 1'b1;
      pulse_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mpoc_pkg::CFG_INVERT: invert_r <= cfg_data[mpoc_pkg::NUM_OUTPUTS-1:0];
        mpoc_pkg::CFG_ACTIVE: active_r <= cfg_data[0];
        mpoc_pkg::CFG_PULSE0: pulse_r[0] <= cfg_data[mpoc_pkg::HOLD_WIDTH-1:0];
        mpoc_pkg::CFG_PULSE1: pulse_r[1] <= cfg_data[mpoc_pkg::HOLD_WIDTH-1:0];
        mpoc_pkg::CFG_PULSE2: pulse_r[2] <= cfg_data[mpoc_pkg::HOLD_WIDTH-1:0];
        mpoc_pkg::CFG_PULSE3: pulse_r[3] <= cfg_data[mpoc_pkg::HOLD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign invert_mask  = invert_r;
  assign active_level = active_r;
  assign min_pulse    = pulse_r;

endmodule
`default_nettype wire

[hdl/mpoc_channel.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpoc_channel
// one output channel: request, applied level, held-tick counter, override
// ----------------------------------------------------------------------------
module mpoc_channel (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mpoc_pkg::chan_cmd_t           cmd,
  input  wire logic [mpoc_pkg::HOLD_WIDTH-1:0] min_pulse,
  output mpoc_pkg::chan_stat_t               stat
);

`include "min_pulse_output_controller_assert.svh"

  logic                          req_r, req_nxt;
  logic                          app_r, app_nxt;
  logic [mpoc_pkg::HOLD_WIDTH-1:0] held_r, held_nxt;
  logic                          ovr_r, ovr_nxt;
  logic                          ovv_r, ovv_nxt;
  logic [mpoc_pkg::HOLD_WIDTH-1:0] held_inc;

  // counter advances on every tick while asserted, saturating
  assign held_inc = (app_r && held_r != mpoc_pkg::HOLD_MAX) ?
                    held_r + mpoc_pkg::HOLD_ONE : held_r;

  always_comb begin
    req_nxt  = req_r;
    app_nxt  = app_r;
    held_nxt = held_r;
    ovr_nxt  = ovr_r;
    ovv_nxt  = ovv_r;
    if (cmd.fire) begin
      unique case (cmd.opcode)
        mpoc_pkg::OP_SET: begin
          if (cmd.sel && !ovr_r) begin
            req_nxt = cmd.level_req;
            if (cmd.enabled && cmd.level_req) begin
              app_nxt = 1'b1;
              if (!app_r) held_nxt = '0;
            end
          end
        end
        mpoc_pkg::OP_TICK: begin
          held_nxt = held_inc;
          if (cmd.enabled && !ovr_r) begin
            if (!req_r && app_r) begin
              if (held_inc >= min_pulse) app_nxt = 1'b0;
            end else if (req_r && !app_r) begin
              app_nxt  = 1'b1;
              held_nxt = '0;
            end
          end
        end
        mpoc_pkg::OP_FORCE: begin
          if (cmd.sel) begin
            ovv_nxt = cmd.level_req;
            if (cmd.force_on) begin
              ovr_nxt = 1'b1;
              app_nxt = cmd.level_req;
              if (cmd.level_req) held_nxt = '0;
            end else begin
              // release falls back to the request at once
              ovr_nxt = 1'b0;
              app_nxt = req_r;
              if (req_r && !app_r) held_nxt = '0;
            end
          end
        end
        mpoc_pkg::OP_ENABLE: begin
          if (!cmd.enabled && !ovr_r && req_r != app_r) begin
            app_nxt = req_r;
            if (req_r) held_nxt = '0;
          end
        end
        mpoc_pkg::OP_CLEAR: begin
          if (ovr_r) begin
            ovr_nxt = 1'b0;
            ovv_nxt = 1'b0;
            app_nxt = req_r;
            if (req_r && !app_r) held_nxt = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r  <= 1'b0;
      app_r  <= 1'b0;
      held_r <= '0;
      ovr_r  <= 1'b0;
      ovv_r  <= 1'b0;
    end else begin
      req_r  <= req_nxt;
      app_r  <= app_nxt;
      held_r <= held_nxt;
      ovr_r  <= ovr_nxt;
      ovv_r  <= ovv_nxt;
    end
  end

  // status reflects the state after this request
  assign stat.logical = ovr_nxt ? ovv_nxt : app_nxt;
  assign stat.forced  = ovr_nxt;

  `MPOC_ASSERT_IMPLY(a_rise_restarts_count, clk, rst_n, $rose(app_r), held_r == '0)
  `MPOC_ASSERT_NEXT(a_idle_holds_state, clk, rst_n, !cmd.fire,
                    $stable(app_r) && $stable(ovr_r) && $stable(held_r))
  `MPOC_ASSERT_NEXT(a_forced_ignores_set, clk, rst_n,
                    cmd.fire && cmd.opcode == mpoc_pkg::OP_SET && ovr_r, $stable(req_r))

endmodule
`default_nettype wire

[hdl/min_pulse_output_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_pulse_output_controller
// four-channel output controller with minimum pulse width and force override
// ----------------------------------------------------------------------------
// Takes one request per clock and returns one result per request: the
// request lands in an input register, the channels update their state from
// it in a single pass, and the result register captures the pin, logical
// and forced masks. A stall on the result side holds the result register
// and, in the same cycle, stalls the input side only when the input
// register is also full, so throughput stays at one request per clock
// while the consumer keeps up.
module min_pulse_output_controller (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire mpoc_pkg::in_item_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output mpoc_pkg::out_item_t                     out_data,
  input  wire logic                               cfg_we,
  input  wire logic [mpoc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mpoc_pkg::CFG_DATA_W-1:0]    cfg_data
);

`include "min_pulse_output_controller_assert.svh"

  logic                                                       in_valid_r;
  mpoc_pkg::in_item_t                                         in_data_r;
  logic                                                       out_valid_r;
  mpoc_pkg::out_item_t                                        out_data_r;
  mpoc_pkg::out_item_t                                        out_data_nxt;
  logic                                                       en_r, en_nxt;
  logic                                                       advance;
  logic                                                       proc;
  logic [mpoc_pkg::NUM_OUTPUTS-1:0]                           invert_mask;
  logic                                                       active_level;
  logic [mpoc_pkg::NUM_OUTPUTS-1:0][mpoc_pkg::HOLD_WIDTH-1:0] min_pulse;
  mpoc_pkg::chan_stat_t                                       stat [mpoc_pkg::NUM_OUTPUTS];

  assign advance  = !out_valid_r || !out_stall;
  assign proc     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  assign en_nxt = en_r || (proc && in_data_r.opcode == mpoc_pkg::OP_ENABLE);

  mpoc_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .invert_mask  (invert_mask),
    .active_level (active_level),
    .min_pulse    (min_pulse)
  );

  for (genvar i = 0; i < mpoc_pkg::NUM_OUTPUTS; i++) begin : g_chan
    localparam logic [1:0] CH_ID = 2'(i);
    mpoc_pkg::chan_cmd_t cmd;

    always_comb begin
      cmd.fire      = proc;
      cmd.opcode    = in_data_r.opcode;
      cmd.sel       = in_data_r.channel == CH_ID;
      cmd.level_req = in_data_r.level_req;
      cmd.force_on  = in_data_r.force_on;
      cmd.enabled   = en_r;
    end

    mpoc_channel u_chan (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .min_pulse (min_pulse[i]),
      .stat      (stat[i])
    );
  end

  always_comb begin
    for (int i = 0; i < mpoc_pkg::NUM_OUTPUTS; i++) begin
      // asserted drives the active level, then per-pin inversion
      out_data_nxt.pin_levels[i]   = ~(stat[i].logical ^ active_level) ^ invert_mask[i];
      out_data_nxt.logical_mask[i] = stat[i].logical;
      out_data_nxt.forced_mask[i]  = stat[i].forced;
    end
    out_data_nxt.outputs_on = en_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      en_r        <= 1'b0;
    end else begin
      if (!in_stall) in_valid_r <= in_valid;
      if (advance) out_valid_r <= in_valid_r;
      en_r <= en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_data_r <= in_data;
    if (proc) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MPOC_ASSERT_NEXT(a_proc_loads_result, clk, rst_n, proc, out_valid_r)
  `MPOC_ASSERT_NEXT(a_enable_sticks, clk, rst_n, en_r, en_r)
  `MPOC_ASSERT_NEXT(a_result_flag_matches, clk, rst_n, proc, out_data_r.outputs_on == en_r)

endmodule
`default_nettype wire

[tb/min_pulse_output_controller_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_pulse_output_controller_test
// self-checking bench for the four-channel minimum pulse output controller
// ----------------------------------------------------------------------------
// A queue-fed driver offers requests with random gaps. The driver also feeds
// every accepted request to a behavioral status predictor. A monitor stalls
// at random, and once for a long hold-off. It compares every result with the
// oldest predicted status. Phases step through several register settings,
// including a run of ticks against the widest minimum pulse.
// ----------------------------------------------------------------------------
module min_pulse_output_controller_test;

  localparam int CLK_PERIOD  = 4;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_REPORTS = 10;
  localparam int IDLE_MAX    = 6;

  // opcodes that the block decodes as no-ops
  localparam logic [2:0] OP_RSVD_5 = 3'd5;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  mpoc_pkg::in_item_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  mpoc_pkg::out_item_t             out_data;
  logic                            cfg_we    = 1'b0;
  logic [mpoc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mpoc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  mpoc_pkg::in_item_t  req_q[$];
  mpoc_pkg::out_item_t status_q[$];

  int send_idle_max = 0;
  int recv_idle_max = 0;
  int send_wait     = 0;
  int recv_wait     = 0;
  int hold_token    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int mismatches    = 0;
  int cycle_count   = 0;

  // predictor state
  logic [mpoc_pkg::NUM_OUTPUTS-1:0] m_invert  = '0;
  logic                             m_active  = 1'b1;
  logic [mpoc_pkg::HOLD_WIDTH-1:0]  m_pulse [mpoc_pkg::NUM_OUTPUTS];
  logic [mpoc_pkg::NUM_OUTPUTS-1:0] m_req     = '0;
  logic [mpoc_pkg::NUM_OUTPUTS-1:0] m_applied = '0;
  logic [mpoc_pkg::HOLD_WIDTH-1:0]  m_held [mpoc_pkg::NUM_OUTPUTS];
  logic [mpoc_pkg::NUM_OUTPUTS-1:0] m_forced  = '0;
  logic [mpoc_pkg::NUM_OUTPUTS-1:0] m_fval    = '0;
  logic                             m_enabled = 1'b0;

  min_pulse_output_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // held time restarts on every rising applied level
  function automatic void set_applied(int ch, logic lvl);
    if (lvl && !m_applied[ch]) m_held[ch] = '0;
    m_applied[ch] = lvl;
  endfunction

  function automatic void drop_override(int ch, logic lvl);
    m_forced[ch] = 1'b0;
    m_fval[ch]   = lvl;
    set_applied(ch, m_req[ch]);
  endfunction

  function automatic mpoc_pkg::out_item_t advance_outputs(mpoc_pkg::in_item_t r);
    mpoc_pkg::out_item_t res;
    logic                lg;
    int                  ch;
    ch = r.channel;
    case (r.opcode)
      mpoc_pkg::OP_SET: begin
        if (!m_forced[ch]) begin
          m_req[ch] = r.level_req;
          if (m_enabled && r.level_req) set_applied(ch, 1'b1);
        end
      end
      mpoc_pkg::OP_TICK: begin
        for (int i = 0; i < mpoc_pkg::NUM_OUTPUTS; i++)
          if (m_applied[i] && m_held[i] != mpoc_pkg::HOLD_MAX)
            m_held[i] = m_held[i] + mpoc_pkg::HOLD_ONE;
        if (m_enabled) begin
          for (int i = 0; i < mpoc_pkg::NUM_OUTPUTS; i++) begin
            if (!m_forced[i]) begin
              if (!m_req[i] && m_applied[i]) begin
                if (m_held[i] >= m_pulse[i]) m_applied[i] = 1'b0;
              end else if (m_req[i] && !m_applied[i]) begin
                set_applied(i, 1'b1);
              end
            end
          end
        end
      end
      mpoc_pkg::OP_FORCE: begin
        if (r.force_on) begin
          m_forced[ch]  = 1'b1;
          m_fval[ch]    = r.level_req;
          m_applied[ch] = r.level_req;
          if (r.level_req) m_held[ch] = '0;
        end else begin
          drop_override(ch, r.level_req);
        end
      end
      mpoc_pkg::OP_ENABLE: begin
        if (!m_enabled) begin
          m_enabled = 1'b1;
          for (int i = 0; i < mpoc_pkg::NUM_OUTPUTS; i++)
            if (!m_forced[i] && m_req[i] != m_applied[i]) set_applied(i, m_req[i]);
        end
      end
      mpoc_pkg::OP_CLEAR: begin
        for (int i = 0; i < mpoc_pkg::NUM_OUTPUTS; i++)
          if (m_forced[i]) drop_override(i, 1'b0);
      end
      default: ;
    endcase
    for (int i = 0; i < mpoc_pkg::NUM_OUTPUTS; i++) begin
      lg = m_forced[i] ? m_fval[i] : m_applied[i];
      res.pin_levels[i]   = (lg ? m_active : ~m_active) ^ m_invert[i];
      res.logical_mask[i] = lg;
      res.forced_mask[i]  = m_forced[i];
    end
    res.outputs_on = m_enabled;
    return res;
  endfunction

  function automatic int draw_gap(int max_wait);
    if (max_wait == 0 || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, max_wait);
  endfunction

  // driver: offers queued requests and predicts each accepted one
  always @(posedge clk) begin : driver
    logic taken;
    taken = in_valid && !in_stall;
    if (taken) status_q.push_back(advance_outputs(in_data));
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || taken) begin
      if (send_wait > 0) begin
        send_wait = send_wait - 1;
        in_valid <= 1'b0;
      end else if (req_q.size() > 0) begin
        in_data   <= req_q.pop_front();
        in_valid  <= 1'b1;
        send_wait = draw_gap(send_idle_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks results and drives the result-side stall
  always @(posedge clk) begin : monitor
    mpoc_pkg::out_item_t want;
    if (out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result %h with nothing pending", out_data);
      end else begin
        want = status_q.pop_front();
        if (out_data.pin_levels !== want.pin_levels ||
            out_data.logical_mask !== want.logical_mask ||
            out_data.forced_mask !== want.forced_mask ||
            out_data.outputs_on !== want.outputs_on) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch at cycle %0d: pins %h/%h logical %h/%h forced %h/%h on %b/%b",
                     cycle_count, want.pin_levels, out_data.pin_levels,
                     want.logical_mask, out_data.logical_mask,
                     want.forced_mask, out_data.forced_mask,
                     want.outputs_on, out_data.outputs_on);
        end
      end
      recv_wait = draw_gap(recv_idle_max);
    end
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (recv_wait > 0) begin
      recv_wait = recv_wait - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [mpoc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mpoc_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      mpoc_pkg::CFG_INVERT: m_invert = val[mpoc_pkg::NUM_OUTPUTS-1:0];
      mpoc_pkg::CFG_ACTIVE: m_active = val[0];
      mpoc_pkg::CFG_PULSE0, mpoc_pkg::CFG_PULSE1,
      mpoc_pkg::CFG_PULSE2, mpoc_pkg::CFG_PULSE3:
        m_pulse[idx - mpoc_pkg::CFG_PULSE0] = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // narrow registers get random upper bits, the block keeps only its width
  task automatic load_settings(input logic [3:0] inv, input logic act,
                               input int p0, input int p1, input int p2, input int p3);
    write_reg(mpoc_pkg::CFG_INVERT, {12'($urandom), inv});
    write_reg(mpoc_pkg::CFG_ACTIVE, {15'($urandom), act});
    write_reg(mpoc_pkg::CFG_PULSE0, 16'(p0));
    write_reg(mpoc_pkg::CFG_PULSE1, 16'(p1));
    write_reg(mpoc_pkg::CFG_PULSE2, 16'(p2));
    write_reg(mpoc_pkg::CFG_PULSE3, 16'(p3));
  endtask

  task automatic push_req(input logic [2:0] op, input int ch, input logic lvl, input logic fon);
    mpoc_pkg::in_item_t r;
    r.opcode    = op;
    r.channel   = 2'(ch);
    r.level_req = lvl;
    r.force_on  = fon;
    req_q.push_back(r);
  endtask

  // mostly set and tick traffic so pulses get asserted, held and released
  task automatic push_random(input int count);
    int          w;
    logic [2:0]  op;
    for (int n = 0; n < count; n++) begin
      w = $urandom_range(0, 99);
      if (w < 35)      op = mpoc_pkg::OP_SET;
      else if (w < 75) op = mpoc_pkg::OP_TICK;
      else if (w < 87) op = mpoc_pkg::OP_FORCE;
      else if (w < 90) op = mpoc_pkg::OP_ENABLE;
      else if (w < 94) op = mpoc_pkg::OP_CLEAR;
      else             op = 3'($urandom_range(OP_RSVD_5, OP_RSVD_7));
      push_req(op, $urandom_range(0, mpoc_pkg::NUM_OUTPUTS - 1), 1'($urandom), 1'($urandom));
    end
  endtask

  // returns on a falling edge once every request has been checked
  task automatic wait_idle();
    do @(negedge clk);
    while (req_q.size() != 0 || in_valid || status_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    for (int i = 0; i < mpoc_pkg::NUM_OUTPUTS; i++) begin
      m_pulse[i] = '0;
      m_held[i]  = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    load_settings(4'h0, 1'b1, 2, 0, 3, 1);
    @(negedge clk);
    send_idle_max = IDLE_MAX;
    recv_idle_max = IDLE_MAX;
    // outputs still disabled: requests recorded, time passes under force
    push_req(mpoc_pkg::OP_SET,    0, 1'b1, 1'b0);
    push_req(mpoc_pkg::OP_TICK,   0, 1'b0, 1'b0);
    push_req(mpoc_pkg::OP_FORCE,  1, 1'b1, 1'b1);
    push_req(mpoc_pkg::OP_TICK,   2, 1'b1, 1'b1);
    push_req(mpoc_pkg::OP_FORCE,  1, 1'b0, 1'b0);
    push_req(mpoc_pkg::OP_FORCE,  2, 1'b0, 1'b1);
    push_req(mpoc_pkg::OP_SET,    2, 1'b1, 1'b0);
    push_req(OP_RSVD_5,           3, 1'b1, 1'b1);
    push_req(OP_RSVD_7,           3, 1'b1, 1'b1);
    push_req(mpoc_pkg::OP_ENABLE, 0, 1'b0, 1'b0);
    push_req(mpoc_pkg::OP_ENABLE, 3, 1'b1, 1'b1);
    push_req(mpoc_pkg::OP_SET,    3, 1'b1, 1'b1);
    push_req(mpoc_pkg::OP_SET,    3, 1'b0, 1'b0);
    push_req(mpoc_pkg::OP_TICK,   0, 1'b0, 1'b0);
    push_req(mpoc_pkg::OP_SET,    0, 1'b0, 1'b0);
    push_req(mpoc_pkg::OP_TICK,   0, 1'b0, 1'b0);
    push_req(mpoc_pkg::OP_TICK,   0, 1'b0, 1'b0);
    push_req(mpoc_pkg::OP_SET,    1, 1'b1, 1'b0);
    push_req(mpoc_pkg::OP_SET,    1, 1'b0, 1'b0);
    push_req(mpoc_pkg::OP_TICK,   1, 1'b0, 1'b0);
    push_req(mpoc_pkg::OP_FORCE,  3, 1'b1, 1'b1);
    push_req(mpoc_pkg::OP_FORCE,  0, 1'b0, 1'b1);
    push_req(mpoc_pkg::OP_CLEAR,  0, 1'b0, 1'b0);
    push_req(mpoc_pkg::OP_FORCE,  2, 1'b1, 1'b0);
    push_req(mpoc_pkg::OP_TICK,   2, 1'b0, 1'b0);
    wait_idle();

    load_settings(4'hf, 1'b0, 0, 65535, 1, 0);
    @(negedge clk);
    push_random(250);
    wait_idle();

    load_settings(4'($urandom), 1'b1, $urandom_range(1, 8), $urandom_range(1, 8),
                  $urandom_range(1, 8), $urandom_range(1, 8));
    @(negedge clk);
    push_random(150);
    wait_idle();
    push_random(150);
    wait_idle();

    // long result-side hold-off while requests keep coming
    send_idle_max = 0;
    hold_token <= hold_token + 1;
    push_random(40);
    wait_idle();

    // release everything, then hold channel 0 against the widest pulse
    load_settings(4'($urandom), 1'($urandom), 0, 0, 0, 0);
    @(negedge clk);
    recv_idle_max = 0;
    push_req(mpoc_pkg::OP_CLEAR, 0, 1'b0, 1'b0);
    for (int i = 0; i < mpoc_pkg::NUM_OUTPUTS; i++) push_req(mpoc_pkg::OP_SET, i, 1'b0, 1'b0);
    push_req(mpoc_pkg::OP_TICK, 0, 1'b0, 1'b0);
    wait_idle();
    write_reg(mpoc_pkg::CFG_PULSE0, mpoc_pkg::HOLD_MAX);
    @(negedge clk);
    push_req(mpoc_pkg::OP_SET, 0, 1'b1, 1'b0);
    for (int n = 0; n < 40; n++) push_req(mpoc_pkg::OP_TICK, 0, 1'b0, 1'b0);
    push_req(mpoc_pkg::OP_SET, 0, 1'b0, 1'b0);
    push_req(mpoc_pkg::OP_TICK, 0, 1'b0, 1'b0);
    push_req(mpoc_pkg::OP_TICK, 0, 1'b0, 1'b0);
    wait_idle();

    load_settings(4'($urandom), 1'($urandom), $urandom_range(0, 10), $urandom_range(0, 10),
                  $urandom_range(0, 10), $urandom_range(0, 10));
    @(negedge clk);
    send_idle_max = IDLE_MAX;
    recv_idle_max = IDLE_MAX;
    push_random(250);
    wait_idle();
    send_idle_max = 0;
    recv_idle_max = 0;
    push_random(120);
    wait_idle();
    send_idle_max = IDLE_MAX;
    recv_idle_max = IDLE_MAX;
    push_random(100);
    wait_idle();

    if (mismatches == 0 && status_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
